// File: design/rsp_pkg.sv
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon parity generator.
package rsp_pkg;

    localparam int MAX_PARITY = 30;
    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam int LEN_W = 5;
    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam logic [LEN_W-1:0] RESET_LENGTH = 5'd10;

    typedef struct packed {
        logic       gen_clear;
        logic       gen_step;
        logic [7:0] root;
        logic       data_step;
        logic       block_end;
        logic [7:0] factor;
        logic       out_shift;
    } rsp_ctrl_t;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY[7:0] : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] a;
        acc = 8'h00;
        a = x;
        for (int i = 0; i < 8; i++)
        begin
            if (y[i])
            begin
                acc = acc ^ a;
            end
            a = gf_xtime(a);
        end
        gf_mul = acc;
    endfunction

    function automatic logic [CNT_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        if (len == '0)
        begin
            eff_length = CNT_W'(1);
        end
        else if (int'(len) > MAX_PARITY)
        begin
            eff_length = CNT_W'(MAX_PARITY);
        end
        else
        begin
            eff_length = CNT_W'(len);
        end
    endfunction

endpackage

// File: design/rsp_channels.sv
// Handshake channel interfaces for data words, parity words and the length register.
interface rsp_data_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

interface rsp_parity_if;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

interface rsp_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rsp_pkg::LEN_W-1:0]   parity_length;

    modport source (output valid, output parity_length, input ready);
    modport sink (input valid, input parity_length, output ready);
endinterface

// File: design/rsp_cell.sv
// One cell of the chain: generator coefficient, remainder byte and parity readout byte.
module rsp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  rsp_pkg::rsp_ctrl_t ctrl,
    input  logic [7:0]        gen_left,
    input  logic [7:0]        rem_right,
    input  logic [7:0]        par_right,
    output logic [7:0]        gen_out,
    output logic [7:0]        rem_out,
    output logic [7:0]        par_out
);
    import rsp_pkg::*;

    logic [7:0] gen_reg;
    logic [7:0] gen_next;
    logic [7:0] rem_reg;
    logic [7:0] rem_next;
    logic [7:0] par_reg;
    logic [7:0] par_next;
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] prod;
    logic [7:0] rem_new;

    // One multiplier serves both the generator build and the data update.
    always_comb
    begin
        mul_a = ctrl.gen_step ? gen_left : gen_reg;
        mul_b = ctrl.gen_step ? ctrl.root : ctrl.factor;
        prod = gf_mul(mul_a, mul_b);
        rem_new = rem_right ^ prod;

        gen_next = gen_reg;
        if (ctrl.gen_clear)
        begin
            gen_next = 8'h00;
        end
        else if (ctrl.gen_step)
        begin
            gen_next = gen_reg ^ prod;
        end

        rem_next = rem_reg;
        if (ctrl.gen_clear)
        begin
            rem_next = 8'h00;
        end
        else if (ctrl.data_step)
        begin
            rem_next = ctrl.block_end ? 8'h00 : rem_new;
        end

        par_next = par_reg;
        if (ctrl.data_step && ctrl.block_end)
        begin
            par_next = rem_new;
        end
        else if (ctrl.out_shift)
        begin
            par_next = par_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= 8'h00;
            rem_reg <= 8'h00;
        end
        else
        begin
            gen_reg <= gen_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg <= par_next;
    end

    assign gen_out = gen_reg;
    assign rem_out = rem_reg;
    assign par_out = par_reg;

endmodule

// File: design/reed_solomon_parity_generator.sv
// Top level of the Reed-Solomon parity generator over GF(256).
//
// Channel   Modport  Payload                       Purpose
// data      sink     data_byte[7:0], block_end     data words of a block
// parity    source   parity_byte[7:0], parity_last parity words, highest degree first
// cfg       sink     parity_length[4:0]            parity length register
//
// A data word is taken in every cycle unless held off (see below); the remainder chain
// updates in the same cycle. After the word that ends a block, its parity words leave
// at one per cycle while parity.ready is high, from a separate readout chain while the
// next block streams in. A word that ends a block waits while the previous block still
// has more than one parity word to deliver, or while its last one is not taken in
// that cycle. After reset or a length write, the generator is rebuilt from the clamped
// parity length (ten after reset); data is held off while it is being rebuilt.
module reed_solomon_parity_generator (
    input  logic               clk,
    input  logic               rst_n,
    rsp_data_if.sink           data,
    rsp_parity_if.source       parity,
    rsp_cfg_if.sink            cfg
);
    import rsp_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [CNT_W-1:0] build_cnt_reg;
    logic [CNT_W-1:0] build_cnt_next;
    logic [7:0]       root_reg;
    logic [7:0]       root_next;
    logic [CNT_W-1:0] out_cnt_reg;
    logic [CNT_W-1:0] out_cnt_next;
    logic [CNT_W-1:0] eff_len;
    logic             building;
    logic             out_free;
    logic             data_acc;
    logic             out_acc;
    logic             cfg_acc;
    rsp_ctrl_t        ctrl;

    logic [7:0] gen_w [MAX_PARITY];
    logic [7:0] rem_w [MAX_PARITY];
    logic [7:0] par_w [MAX_PARITY];

    assign eff_len = eff_length(len_reg);
    assign building = (build_cnt_reg != '0);
    assign out_free = (out_cnt_reg == '0) || ((out_cnt_reg == CNT_W'(1)) && parity.ready);

    assign data.ready = !building && (!data.block_end || out_free);
    assign cfg.ready = 1'b1;

    assign data_acc = data.valid && data.ready;
    assign out_acc = parity.valid && parity.ready;
    assign cfg_acc = cfg.valid && cfg.ready;

    assign parity.valid = (out_cnt_reg != '0);
    assign parity.parity_byte = par_w[0];
    assign parity.parity_last = (out_cnt_reg == CNT_W'(1));

    always_comb
    begin
        ctrl.gen_clear = cfg_acc;
        ctrl.gen_step = !cfg_acc && building;
        ctrl.root = root_reg;
        ctrl.data_step = data_acc;
        ctrl.block_end = data.block_end;
        ctrl.factor = data.data_byte ^ rem_w[0];
        ctrl.out_shift = out_acc;

        len_next = len_reg;
        build_cnt_next = build_cnt_reg;
        root_next = root_reg;
        if (cfg_acc)
        begin
            len_next = cfg.parity_length;
            build_cnt_next = eff_length(cfg.parity_length);
            root_next = 8'h01;
        end
        else if (building)
        begin
            build_cnt_next = build_cnt_reg - CNT_W'(1);
            root_next = gf_xtime(root_reg);
        end

        out_cnt_next = out_cnt_reg;
        if (data_acc && data.block_end)
        begin
            out_cnt_next = eff_len;
        end
        else if (out_acc)
        begin
            out_cnt_next = out_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= RESET_LENGTH;
            build_cnt_reg <= eff_length(RESET_LENGTH);
            root_reg <= 8'h01;
            out_cnt_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            build_cnt_reg <= build_cnt_next;
            root_reg <= root_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    for (genvar i = 0; i < MAX_PARITY; i++)
    begin : g_cell
        logic [7:0] gen_left;
        logic [7:0] rem_right;
        logic [7:0] par_right;

        if (i == 0)
        begin : g_head
            assign gen_left = 8'h01;
        end
        else
        begin : g_body
            assign gen_left = gen_w[i-1];
        end

        if (i == MAX_PARITY - 1)
        begin : g_tail
            assign rem_right = 8'h00;
            assign par_right = 8'h00;
        end
        else
        begin : g_link
            assign rem_right = rem_w[i+1];
            assign par_right = par_w[i+1];
        end

        rsp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .gen_left  (gen_left),
            .rem_right (rem_right),
            .par_right (par_right),
            .gen_out   (gen_w[i]),
            .rem_out   (rem_w[i]),
            .par_out   (par_w[i])
        );
    end

`ifndef SYNTHESIS
    a_no_data_while_building: assert property (@(posedge clk) disable iff (!rst_n)
        data_acc |-> !building)
        else $error("data word accepted while the generator is being rebuilt");

    a_out_count_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (data_acc && data.block_end) |=> (out_cnt_reg == $past(eff_len)))
        else $error("parity count not loaded with the block length");

    a_out_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(out_cnt_reg) <= MAX_PARITY)
        else $error("parity count beyond the chain length");

    a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && parity.parity_last && !(data_acc && data.block_end)) |=> !parity.valid)
        else $error("parity words continue after the last one");

    a_build_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> (building && (root_reg == 8'h01)))
        else $error("generator rebuild did not start after a length write");
`endif

endmodule

// File: test/reed_solomon_parity_generator_tb.sv
// Testbench for the Reed-Solomon parity generator: random handshakes checked against a predictor.
`timescale 1ns / 1ps

module reed_solomon_parity_generator_tb;

    localparam int CLK_PERIOD = 20;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int RANDOM_WORDS = 360;
    localparam int NPAR = rsp_pkg::MAX_PARITY;
    localparam int LW = rsp_pkg::LEN_W;
    localparam logic [7:0] FIELD_LOW = 8'h1D;

    typedef enum logic {ITEM_WORD, ITEM_LENGTH} item_kind_t;

    typedef struct {
        item_kind_t      kind;
        logic [7:0]      data_byte;
        logic            block_end;
        logic [LW-1:0]   parity_length;
    } pending_item_t;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       parity_last;
    } parity_word_t;

    logic clk;
    logic rst_n;

    rsp_data_if   data_ch ();
    rsp_parity_if parity_ch ();
    rsp_cfg_if    cfg_ch ();

    reed_solomon_parity_generator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_ch),
        .parity (parity_ch),
        .cfg    (cfg_ch)
    );

    pending_item_t pending_words[$];
    pending_item_t cur_item;
    parity_word_t  parity_due[$];

    logic [LW-1:0] length_reg;
    logic [7:0]    gen_coef [NPAR];
    logic [7:0]    rem_cells [NPAR];

    logic data_fire = 1'b0;
    logic cfg_fire = 1'b0;
    logic parity_fire = 1'b0;
    bit   word_busy = 1'b0;
    bit   length_busy = 1'b0;
    bit   sender_steady = 1'b0;
    bit   receiver_steady = 1'b0;
    int   gap_left = 0;
    int   settle_left = SETTLE_CYCLES;
    int   stall_left = 0;
    int   mismatch_count = 0;

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            p = {p[6:0], 1'b0} ^ (p[7] ? FIELD_LOW : 8'h00);
            if (b[i])
                p = p ^ a;
        end
        return p;
    endfunction

    function automatic int degree_of(input logic [LW-1:0] len);
        if (len == '0)
            return 1;
        if (int'(len) > NPAR)
            return NPAR;
        return int'(len);
    endfunction

    task automatic load_parity_length(input logic [LW-1:0] len);
        logic [7:0] poly [NPAR + 1];
        logic [7:0] root;
        int deg;
        deg = degree_of(len);
        length_reg = len;
        root = 8'h01;
        foreach (poly[k])
            poly[k] = 8'h00;
        poly[0] = 8'h01;
        for (int i = 0; i < deg; i++)
        begin
            for (int k = i + 1; k >= 1; k--)
                poly[k] = poly[k] ^ gf_product(poly[k - 1], root);
            root = gf_product(root, 8'h02);
        end
        for (int i = 0; i < NPAR; i++)
        begin
            gen_coef[i] = (i < deg) ? poly[i + 1] : 8'h00;
            rem_cells[i] = 8'h00;
        end
    endtask

    task automatic absorb_data_word(input logic [7:0] data_byte, input logic block_end);
        logic [7:0] factor;
        parity_word_t pw;
        int n;
        n = degree_of(length_reg);
        factor = data_byte ^ rem_cells[0];
        for (int i = 0; i + 1 < n; i++)
            rem_cells[i] = rem_cells[i + 1];
        rem_cells[n - 1] = 8'h00;
        for (int i = 0; i < n; i++)
            rem_cells[i] = rem_cells[i] ^ gf_product(gen_coef[i], factor);
        if (block_end)
        begin
            for (int i = 0; i < n; i++)
            begin
                pw.parity_byte = rem_cells[i];
                pw.parity_last = (i + 1 == n);
                parity_due.push_back(pw);
            end
            for (int i = 0; i < NPAR; i++)
                rem_cells[i] = 8'h00;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    function automatic void push_word(input logic [7:0] data_byte, input logic block_end);
        pending_item_t it;
        it.kind = ITEM_WORD;
        it.data_byte = data_byte;
        it.block_end = block_end;
        it.parity_length = '0;
        pending_words.push_back(it);
    endfunction

    function automatic void push_length(input logic [LW-1:0] len);
        pending_item_t it;
        it.kind = ITEM_LENGTH;
        it.data_byte = 8'h00;
        it.block_end = 1'b0;
        it.parity_length = len;
        pending_words.push_back(it);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            data_fire <= data_ch.valid && data_ch.ready;
            cfg_fire <= cfg_ch.valid && cfg_ch.ready;
            parity_fire <= parity_ch.valid && parity_ch.ready;
            if (data_ch.valid && data_ch.ready)
                absorb_data_word(data_ch.data_byte, data_ch.block_end);
            if (cfg_ch.valid && cfg_ch.ready)
                load_parity_length(cfg_ch.parity_length);
            if (parity_ch.valid && parity_ch.ready)
            begin
                if (parity_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected parity word %02h, last %0b",
                        parity_ch.parity_byte, parity_ch.parity_last));
                end
                else
                begin
                    parity_word_t want;
                    want = parity_due.pop_front();
                    if (parity_ch.parity_byte !== want.parity_byte)
                        report_mismatch($sformatf("parity_byte is %02h, expected %02h",
                            parity_ch.parity_byte, want.parity_byte));
                    if (parity_ch.parity_last !== want.parity_last)
                        report_mismatch($sformatf("parity_last is %0b, expected %0b",
                            parity_ch.parity_last, want.parity_last));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (data_fire || cfg_fire)
            begin
                word_busy = 1'b0;
                length_busy = 1'b0;
                gap_left = sender_steady ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 24) == 0)
                    sender_steady = !sender_steady;
            end
            if (!word_busy && !length_busy && pending_words.size() > 0)
            begin
                if (pending_words[0].kind == ITEM_WORD)
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        cur_item = pending_words.pop_front();
                        word_busy = 1'b1;
                    end
                end
                else if (parity_due.size() != 0)
                begin
                    settle_left = SETTLE_CYCLES;
                end
                else if (settle_left > 0)
                begin
                    settle_left--;
                end
                else
                begin
                    cur_item = pending_words.pop_front();
                    length_busy = 1'b1;
                    settle_left = SETTLE_CYCLES;
                end
            end
            data_ch.valid <= word_busy;
            data_ch.data_byte <= cur_item.data_byte;
            data_ch.block_end <= cur_item.block_end;
            cfg_ch.valid <= length_busy;
            cfg_ch.parity_length <= cur_item.parity_length;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (parity_fire)
            begin
                stall_left = receiver_steady ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 24) == 0)
                    receiver_steady = !receiver_steady;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                parity_ch.ready <= 1'b0;
            end
            else
            begin
                parity_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int words;
        int span;
        rst_n = 1'b0;
        data_ch.valid = 1'b0;
        data_ch.data_byte = 8'h00;
        data_ch.block_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.parity_length = '0;
        parity_ch.ready = 1'b0;
        cur_item = '{ITEM_WORD, 8'h00, 1'b0, '0};
        load_parity_length(rsp_pkg::RESET_LENGTH);

        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h80, 1'b1);
        push_word(8'hFF, 1'b1);
        push_word(8'h01, 1'b1);
        // A length write in the middle of a block discards the partial remainder.
        push_word(8'h55, 1'b0);
        push_length(LW'(7));
        push_word(8'hAA, 1'b0);
        push_word(8'h00, 1'b1);
        push_length(LW'(30));
        push_word(8'hFF, 1'b0);
        push_word(8'h7E, 1'b1);
        push_word(8'h81, 1'b1);
        // Lengths of zero and above the maximum are clamped.
        push_length(LW'(0));
        push_word(8'h12, 1'b1);
        push_word(8'h34, 1'b0);
        push_word(8'hFE, 1'b1);
        push_length(LW'(31));
        push_word(8'h7F, 1'b1);
        push_word(8'hC3, 1'b1);
        push_length(LW'(1));
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b1);

        words = 0;
        while (words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
                push_length(LW'($urandom_range(0, 31)));
            else
                push_length(LW'($urandom_range(7, 30)));
            repeat ($urandom_range(1, 5))
            begin
                span = $urandom_range(1, 12);
                for (int k = 0; k < span; k++)
                    push_word(8'($urandom_range(0, 255)), k == span - 1);
                words += span;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                span = $urandom_range(1, 4);
                repeat (span)
                    push_word(8'($urandom_range(0, 255)), 1'b0);
                words += span;
            end
        end
        push_length(LW'(30));
        push_word(8'($urandom_range(0, 255)), 1'b0);
        push_word(8'($urandom_range(0, 255)), 1'b1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || word_busy || length_busy || parity_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && parity_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule
